/* src/assert_macros.svh */
// Assertion macros for the checker file of the key record/replay block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define KRR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("krr assertion failed");

// Condition in one cycle implies a condition in the next cycle
`define KRR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("krr assertion failed");

`endif

/* src/krr_pkg.sv */
// Shared types and constants of the key record/replay edge detector.
// Depends on nothing; imported by every module of the block.
package krr_pkg;

	localparam int KEY_W       = 11;   // key mask width
	localparam int FIELD_W     = 11;   // count and limit field width
	localparam int STORE_DEPTH = 1024; // frames in the store
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(STORE_DEPTH);

	// Request opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_REC   = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_PLAY  = 2'd3;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_RECORD = 3'b010,
		MODE_PLAY   = 3'b100
	} mode_t;

	// How stage 1 forms the new key state
	typedef enum logic [3:0] {
		KIND_HOLD   = 4'b0001, // command: state unchanged
		KIND_SAMPLE = 4'b0010, // live sample
		KIND_FRAME  = 4'b0100, // stored frame from the RAM
		KIND_END    = 4'b1000  // playback ran out: zero state
	} kind_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key_mask;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]   pressed_keys;
		logic [KEY_W-1:0]   newly_pressed;
		logic [KEY_W-1:0]   newly_released;
		logic               playing;
		logic [FIELD_W-1:0] recorded_frames;
	} rsp_t;

endpackage

/* src/key_record_replay_edge_detect.sv */
// Top level of the key record/replay edge detector: control, stage 1, output.
// Depends on krr_pkg and krr_frame_ram.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  request   | in        | req_valid / req_stall  | req  (opcode, key_mask)
//  response  | out       | rsp_valid / rsp_stall  | rsp  (keys, edges, playing, count)
//  config    | in        | cfg_we                 | cfg_wdata (record_limit)
//
// One request per cycle unless the response stalls; the response passes the stage 1
// and output registers (store read on accept, key and edge update on advance).
// arst_n clears mode, counters, key state and valid flags and sets the limit to the
// store depth; the frame store is not cleared and needs no clearing pass.
// A stalled response holds; stage 1 still takes one more request behind it.
// Record writes and playback reads never hit the same entry in flight.
module key_record_replay_edge_detect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  krr_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output krr_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [krr_pkg::FIELD_W-1:0] cfg_wdata
);
	import krr_pkg::*;

	// Control state
	mode_t              mode_q, mode_d;
	logic [CNT_W-1:0]   rec_cnt_q, rec_cnt_d;
	logic [CNT_W-1:0]   play_idx_q, play_idx_d;
	logic [FIELD_W-1:0] limit_q;
	logic [CNT_W-1:0]   limit_sat;

	// Stage 1
	logic               valid_s1;
	kind_t              kind_s1;
	kind_t              kind_d;
	logic [KEY_W-1:0]   sample_s1;
	logic               playing_s1;
	logic [CNT_W-1:0]   frames_s1;

	// Output register, also the architectural key state
	logic               out_valid_q;
	rsp_t               out_q;

	logic               accept;
	logic               advance;
	logic               wr_en;
	logic               rd_en;
	logic [KEY_W-1:0]   rd_data;
	logic [KEY_W-1:0]   new_keys;
	logic [KEY_W-1:0]   prev_keys;

	// Handshake
	assign advance   = valid_s1 && (!out_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	// Record limit saturated to the store depth
	always_comb begin
		if (CNT_W'(limit_q) > CNT_W'(STORE_DEPTH)) begin
			limit_sat = CNT_W'(STORE_DEPTH);
		end else begin
			limit_sat = CNT_W'(limit_q);
		end
	end

	// Request decode: next mode, counters and store access
	always_comb begin
		mode_d     = mode_q;
		rec_cnt_d  = rec_cnt_q;
		play_idx_d = play_idx_q;
		kind_d     = KIND_HOLD;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		unique case (req.opcode)
			OP_TICK: begin
				if (mode_q == MODE_PLAY) begin
					if (play_idx_q < rec_cnt_q) begin
						kind_d     = KIND_FRAME;
						rd_en      = accept;
						play_idx_d = play_idx_q + CNT_W'(1);
					end else begin
						kind_d = KIND_END;
						mode_d = MODE_NORMAL;
					end
				end else begin
					kind_d = KIND_SAMPLE;
					if (mode_q == MODE_RECORD && rec_cnt_q < limit_sat) begin
						wr_en     = accept;
						rec_cnt_d = rec_cnt_q + CNT_W'(1);
					end
				end
			end
			OP_REC: begin
				mode_d    = MODE_RECORD;
				rec_cnt_d = '0;
			end
			OP_STOP: begin
				if (mode_q == MODE_RECORD) begin
					mode_d = MODE_NORMAL;
				end
			end
			OP_PLAY: begin
				mode_d     = MODE_PLAY;
				play_idx_d = '0;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	// Control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			rec_cnt_q  <= '0;
			play_idx_q <= '0;
			limit_q    <= LIMIT_RESET;
		end else begin
			if (accept) begin
				mode_q     <= mode_d;
				rec_cnt_q  <= rec_cnt_d;
				play_idx_q <= play_idx_d;
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	// Frame store
	krr_frame_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (rec_cnt_q[ADDR_W-1:0]),
		.wr_data (req.key_mask),
		.rd_en   (rd_en),
		.rd_addr (play_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= KIND_HOLD;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				kind_s1  <= kind_d;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1  <= req.key_mask;
			playing_s1 <= (mode_d == MODE_PLAY);
			frames_s1  <= rec_cnt_d;
		end
	end

	// New key state
	assign prev_keys = out_q.pressed_keys;

	always_comb begin
		unique case (kind_s1)
			KIND_HOLD:   new_keys = prev_keys;
			KIND_SAMPLE: new_keys = sample_s1;
			KIND_FRAME:  new_keys = rd_data;
			KIND_END:    new_keys = '0;
			default:     new_keys = prev_keys;
		endcase
	end

	// Output register; edges recomputed on ticks only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q           <= 1'b1;
				out_q.pressed_keys    <= new_keys;
				out_q.playing         <= playing_s1;
				out_q.recorded_frames <= FIELD_W'(frames_s1);
				if (kind_s1 != KIND_HOLD) begin
					out_q.newly_pressed  <= new_keys & ~prev_keys;
					out_q.newly_released <= prev_keys & ~new_keys;
				end
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

/* src/krr_frame_ram.sv */
// Frame store: single write port, single read port, registered read data.
// Depends on krr_pkg for depth and widths.
module krr_frame_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [krr_pkg::ADDR_W-1:0] wr_addr,
	input  logic [krr_pkg::KEY_W-1:0]  wr_data,
	input  logic                       rd_en,
	input  logic [krr_pkg::ADDR_W-1:0] rd_addr,
	output logic [krr_pkg::KEY_W-1:0]  rd_data
);
	import krr_pkg::*;

	logic [KEY_W-1:0] mem_q [STORE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/krr_checker.sv */
// Port-level checker for the key record/replay edge detector, bound to the top.
// Depends on krr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module krr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input krr_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input krr_pkg::rsp_t rsp
);
	import krr_pkg::*;

	// A stalled request holds
	`KRR_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req))

	// A stalled response holds
	`KRR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// Press edges only on keys now down, release edges only on keys now up
	`KRR_ASSERT(a_press_sub, clk, arst_n, !rsp_valid || (rsp.newly_pressed & ~rsp.pressed_keys) == '0)
	`KRR_ASSERT(a_release_sub, clk, arst_n, !rsp_valid || (rsp.newly_released & rsp.pressed_keys) == '0)

	// Recording never exceeds the store
	`KRR_ASSERT(a_frames_max, clk, arst_n, !rsp_valid || rsp.recorded_frames <= FIELD_W'(STORE_DEPTH))

endmodule

bind key_record_replay_edge_detect krr_checker u_krr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
